// ----- hw/rtl/mmhs_pkg.sv -----
// shared types and constants for the mergeable min-heap sets block
`default_nettype none

package mmhs_pkg;

	// field widths fixed by the item format
	localparam int unsigned OP_W   = 2;
	localparam int unsigned ELEM_W = 10;
	localparam int unsigned KEY_W  = 32;
	localparam int unsigned RANK_W = 4;

	localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

	// operation codes
	localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
	localparam logic [OP_W-1:0] OP_MERGE   = 2'd1;
	localparam logic [OP_W-1:0] OP_EXTRACT = 2'd2;

	// one command beat as held by the engine
	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic [ELEM_W-1:0]        elem_a;
		logic [ELEM_W-1:0]        elem_b;
		logic signed [KEY_W-1:0]  key_in;
	} cmd_t;

	// one result beat
	typedef struct packed {
		logic                     found;
		logic signed [KEY_W-1:0]  min_key;
		logic [ELEM_W-1:0]        min_index;
	} res_t;

	// engine sequencer states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_MCHK_A,
		ST_MCHK_B,
		ST_FIND,
		ST_COMP,
		ST_RET,
		ST_MRK_A,
		ST_MRK_B,
		ST_MINC,
		ST_XCHK,
		ST_SCAN,
		ST_WALK,
		ST_XEND,
		ST_RESULT
	} state_t;

	// where a find with compression returns to
	typedef enum logic [1:0] {
		RET_MA,
		RET_MB,
		RET_X
	} ret_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mmhs_req_if.sv -----
// command channel: valid, ready and one command beat
`default_nettype none

interface mmhs_req_if
	import mmhs_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          op;
	logic [ELEM_W-1:0]        elem_a;
	logic [ELEM_W-1:0]        elem_b;
	logic signed [KEY_W-1:0]  key_in;

	modport source (output valid, output op, output elem_a, output elem_b,
		output key_in, input ready);
	modport sink (input valid, input op, input elem_a, input elem_b,
		input key_in, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/mmhs_rsp_if.sv -----
// result channel: valid, ready and one result beat
`default_nettype none

interface mmhs_rsp_if
	import mmhs_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic                     found;
	logic signed [KEY_W-1:0]  min_key;
	logic [ELEM_W-1:0]        min_index;

	modport source (output valid, output found, output min_key, output min_index,
		input ready);
	modport sink (input valid, input found, input min_key, input min_index,
		output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/mergeable_min_heap_sets.sv -----
// top level: mergeable min-heap sets with command and result channels
`default_nettype none

// A table of NUM_ELEMENTS elements, each with a signed key and a live mark,
// grouped into disjoint sets kept as a union-find forest in a link memory
// (parent, rank, removed) next to a key memory. Load writes a key and makes
// the element a live root; merge joins two sets by rank with path
// compression; extract removes and returns the smallest live key of a set,
// ties to the lower index, or a not-found beat for an element that is
// removed or out of range. After reset the block writes every link entry
// before it takes its first command. One command is in work at a time, as
// a sequence of reads and write-backs on the link memory port: a merge
// walks the paths of both elements to their roots and compresses them,
// and an extract walks the asked element's path and then the path from
// every live element to its root, so deep trees lengthen it. A result
// register holds a finished beat so the next command is taken while it
// waits.
module mergeable_min_heap_sets
	import mmhs_pkg::*;
#(
	parameter int unsigned NUM_ELEMENTS = 1024
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mmhs_req_if.sink   req,
	mmhs_rsp_if.source rsp
);
	cmd_t  cmd;
	res_t  eng_res;
	res_t  res_q;
	logic  cmd_ready, cmd_fire;
	logic  res_valid, res_ready;
	logic  out_valid_q;

	// command beat into the engine
	assign cmd       = '{op: req.op, elem_a: req.elem_a, elem_b: req.elem_b,
		key_in: req.key_in};
	assign req.ready = cmd_ready;
	assign cmd_fire  = req.valid && cmd_ready;

	mmhs_engine #(
		.NUM_ELEMENTS (NUM_ELEMENTS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_fire  (cmd_fire),
		.cmd       (cmd),
		.cmd_ready (cmd_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (eng_res)
	);

	// result register
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= eng_res;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.found     = res_q.found;
	assign rsp.min_key   = res_q.min_key;
	assign rsp.min_index = res_q.min_index;
endmodule

`default_nettype wire

// ----- hw/rtl/mmhs_ram.sv -----
// single-port-write, single-port-read synchronous ram with registered read data
`default_nettype none

module mmhs_ram #(
	parameter int unsigned WIDTH = 15,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [$clog2(DEPTH)-1:0]  waddr,
	input  wire logic [WIDTH-1:0]          wdata,
	input  wire logic                      re,
	input  wire logic [$clog2(DEPTH)-1:0]  raddr,
	output      logic [WIDTH-1:0]          rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

`default_nettype wire

// ----- hw/rtl/mmhs_engine.sv -----
// sequencer for load, merge and extract over the link and key memories
`default_nettype none

module mmhs_engine
	import mmhs_pkg::*;
#(
	parameter int unsigned NUM_ELEMENTS = 1024
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cmd_fire,
	input  wire cmd_t  cmd,
	output      logic  cmd_ready,
	output      logic  res_valid,
	input  wire logic  res_ready,
	output      res_t  res
);
	localparam int unsigned IW = $clog2(NUM_ELEMENTS);
	localparam logic [IW-1:0] LAST = IW'(NUM_ELEMENTS - 1);

	// one entry of the link memory
	typedef struct packed {
		logic              removed;
		logic [RANK_W-1:0] rank;
		logic [IW-1:0]     parent;
	} link_t;

	// memory ports
	logic                     link_we, link_re;
	logic [IW-1:0]            link_waddr, link_raddr;
	link_t                    link_wdata, link_rdata;
	logic                     key_we, key_re;
	logic [IW-1:0]            key_waddr, key_raddr;
	logic signed [KEY_W-1:0]  key_wdata, key_rdata;

	// control registers
	state_t         state_q, state_d;
	ret_t           ret_q, ret_d;
	logic [IW-1:0]  clr_q, clr_d;
	logic [IW-1:0]  idx_q, idx_d;
	logic [IW-1:0]  cur_q, cur_d;
	logic [IW-1:0]  org_q, org_d;
	logic           have_q, have_d;

	// payload registers
	cmd_t                     cmd_q, cmd_d;
	logic [IW-1:0]            root_q, root_d;
	logic [IW-1:0]            ra_q, ra_d;
	link_t                    ent_q, ent_d;
	link_t                    best_ent_q, best_ent_d;
	logic [IW-1:0]            best_idx_q, best_idx_d;
	logic signed [KEY_W-1:0]  best_key_q, best_key_d;
	logic                     rem_a_q, rem_a_d;
	res_t                     res_q, res_d;

	// scan helpers
	logic   step_next, is_member;
	link_t  cand_ent;

	logic [IW-1:0] a_idx, b_idx;
	logic          a_ok, b_ok;

	assign a_idx = IW'(cmd_q.elem_a);
	assign b_idx = IW'(cmd_q.elem_b);
	assign a_ok  = 32'(cmd_q.elem_a) < 32'(NUM_ELEMENTS);
	assign b_ok  = 32'(cmd_q.elem_b) < 32'(NUM_ELEMENTS);

	mmhs_ram #(
		.WIDTH ($bits(link_t)),
		.DEPTH (NUM_ELEMENTS)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (link_re),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	mmhs_ram #(
		.WIDTH (KEY_W),
		.DEPTH (NUM_ELEMENTS)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_wdata),
		.re    (key_re),
		.raddr (key_raddr),
		.rdata (key_rdata)
	);

	// next state, memory requests and register updates
	always_comb begin
		state_d    = state_q;
		ret_d      = ret_q;
		clr_d      = clr_q;
		idx_d      = idx_q;
		cur_d      = cur_q;
		org_d      = org_q;
		have_d     = have_q;
		cmd_d      = cmd_q;
		root_d     = root_q;
		ra_d       = ra_q;
		ent_d      = ent_q;
		best_ent_d = best_ent_q;
		best_idx_d = best_idx_q;
		best_key_d = best_key_q;
		rem_a_d    = rem_a_q;
		res_d      = res_q;
		link_we    = 1'b0;
		link_waddr = '0;
		link_wdata = '0;
		link_re    = 1'b0;
		link_raddr = '0;
		key_we     = 1'b0;
		key_waddr  = '0;
		key_wdata  = '0;
		key_re     = 1'b0;
		key_raddr  = '0;
		cmd_ready  = 1'b0;
		res_valid  = 1'b0;
		step_next  = 1'b0;
		is_member  = 1'b0;
		cand_ent   = ent_q;

		unique case (state_q)
			// post-reset pass: every entry its own live root of rank zero
			ST_CLEAR: begin
				link_we    = 1'b1;
				link_waddr = clr_q;
				link_wdata = '{removed: 1'b0, rank: '0, parent: clr_q};
				if (clr_q == LAST) begin
					state_d = ST_IDLE;
				end else begin
					clr_d = clr_q + 1'b1;
				end
			end
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_fire) begin
					cmd_d   = cmd;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (cmd_q.op)
					OP_LOAD: begin
						if (a_ok) begin
							link_we    = 1'b1;
							link_waddr = a_idx;
							link_wdata = '{removed: 1'b0, rank: '0, parent: a_idx};
							key_we     = 1'b1;
							key_waddr  = a_idx;
							key_wdata  = cmd_q.key_in;
						end
						state_d = ST_IDLE;
					end
					OP_MERGE: begin
						if (a_ok && b_ok) begin
							link_re    = 1'b1;
							link_raddr = a_idx;
							state_d    = ST_MCHK_A;
						end else begin
							state_d = ST_IDLE;
						end
					end
					OP_EXTRACT: begin
						if (a_ok) begin
							link_re    = 1'b1;
							link_raddr = a_idx;
							state_d    = ST_XCHK;
						end else begin
							res_d   = '0;
							state_d = ST_RESULT;
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			// merge: both elements must be live
			ST_MCHK_A: begin
				rem_a_d    = link_rdata.removed;
				link_re    = 1'b1;
				link_raddr = b_idx;
				state_d    = ST_MCHK_B;
			end
			ST_MCHK_B: begin
				if (rem_a_q || link_rdata.removed) begin
					state_d = ST_IDLE;
				end else begin
					org_d      = a_idx;
					cur_d      = a_idx;
					ret_d      = RET_MA;
					link_re    = 1'b1;
					link_raddr = a_idx;
					state_d    = ST_FIND;
				end
			end
			// walk up to the root
			ST_FIND: begin
				if (link_rdata.parent == cur_q) begin
					root_d = cur_q;
					if (cur_q == org_q) begin
						state_d = ST_RET;
					end else begin
						cur_d      = org_q;
						link_re    = 1'b1;
						link_raddr = org_q;
						state_d    = ST_COMP;
					end
				end else begin
					cur_d      = link_rdata.parent;
					link_re    = 1'b1;
					link_raddr = link_rdata.parent;
				end
			end
			// second walk: point each node on the path at the root
			ST_COMP: begin
				link_we    = 1'b1;
				link_waddr = cur_q;
				link_wdata = '{removed: link_rdata.removed, rank: link_rdata.rank,
					parent: root_q};
				if (link_rdata.parent == root_q) begin
					state_d = ST_RET;
				end else begin
					cur_d      = link_rdata.parent;
					link_re    = 1'b1;
					link_raddr = link_rdata.parent;
				end
			end
			ST_RET: begin
				unique case (ret_q)
					RET_MA: begin
						ra_d       = root_q;
						org_d      = b_idx;
						cur_d      = b_idx;
						ret_d      = RET_MB;
						link_re    = 1'b1;
						link_raddr = b_idx;
						state_d    = ST_FIND;
					end
					RET_MB: begin
						if (root_q == ra_q) begin
							state_d = ST_IDLE;
						end else begin
							link_re    = 1'b1;
							link_raddr = ra_q;
							state_d    = ST_MRK_A;
						end
					end
					RET_X: begin
						ra_d       = root_q;
						idx_d      = '0;
						have_d     = 1'b0;
						link_re    = 1'b1;
						link_raddr = '0;
						key_re     = 1'b1;
						key_raddr  = '0;
						state_d    = ST_SCAN;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			// union by rank; root_q holds the root of the second element
			ST_MRK_A: begin
				ent_d      = link_rdata;
				link_re    = 1'b1;
				link_raddr = root_q;
				state_d    = ST_MRK_B;
			end
			ST_MRK_B: begin
				link_we = 1'b1;
				if (ent_q.rank < link_rdata.rank) begin
					link_waddr = ra_q;
					link_wdata = '{removed: ent_q.removed, rank: ent_q.rank, parent: root_q};
					state_d    = ST_IDLE;
				end else begin
					link_waddr = root_q;
					link_wdata = '{removed: link_rdata.removed, rank: link_rdata.rank,
						parent: ra_q};
					if (ent_q.rank == link_rdata.rank && ent_q.rank != RANK_MAX) begin
						state_d = ST_MINC;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_MINC: begin
				link_we    = 1'b1;
				link_waddr = ra_q;
				link_wdata = '{removed: ent_q.removed, rank: ent_q.rank + 1'b1,
					parent: ent_q.parent};
				state_d    = ST_IDLE;
			end
			// extract: asked element must be live
			ST_XCHK: begin
				if (link_rdata.removed) begin
					res_d   = '0;
					state_d = ST_RESULT;
				end else begin
					org_d      = a_idx;
					cur_d      = a_idx;
					ret_d      = RET_X;
					link_re    = 1'b1;
					link_raddr = a_idx;
					state_d    = ST_FIND;
				end
			end
			// scan entry idx_q: skip removed, else find its root
			ST_SCAN: begin
				ent_d    = link_rdata;
				cand_ent = link_rdata;
				if (link_rdata.removed) begin
					step_next = 1'b1;
				end else if (link_rdata.parent == idx_q) begin
					step_next = 1'b1;
					is_member = (idx_q == ra_q);
				end else begin
					cur_d      = link_rdata.parent;
					link_re    = 1'b1;
					link_raddr = link_rdata.parent;
					state_d    = ST_WALK;
				end
			end
			ST_WALK: begin
				if (link_rdata.parent == cur_q) begin
					step_next = 1'b1;
					is_member = (cur_q == ra_q);
				end else begin
					cur_d      = link_rdata.parent;
					link_re    = 1'b1;
					link_raddr = link_rdata.parent;
				end
			end
			// mark the winner removed and report it
			ST_XEND: begin
				if (have_q) begin
					link_we    = 1'b1;
					link_waddr = best_idx_q;
					link_wdata = '{removed: 1'b1, rank: best_ent_q.rank,
						parent: best_ent_q.parent};
					res_d      = '{found: 1'b1, min_key: best_key_q,
						min_index: ELEM_W'(best_idx_q)};
				end else begin
					res_d = '0;
				end
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// scan bookkeeping: keep the best member, move to the next entry
		if (step_next) begin
			if (is_member && (!have_q || key_rdata < best_key_q)) begin
				have_d     = 1'b1;
				best_idx_d = idx_q;
				best_key_d = key_rdata;
				best_ent_d = cand_ent;
			end
			if (idx_q == LAST) begin
				state_d = ST_XEND;
			end else begin
				idx_d      = idx_q + 1'b1;
				link_re    = 1'b1;
				link_raddr = idx_q + 1'b1;
				key_re     = 1'b1;
				key_raddr  = idx_q + 1'b1;
				state_d    = ST_SCAN;
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ret_q   <= RET_MA;
			clr_q   <= '0;
			idx_q   <= '0;
			cur_q   <= '0;
			org_q   <= '0;
			have_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			clr_q   <= clr_d;
			idx_q   <= idx_d;
			cur_q   <= cur_d;
			org_q   <= org_d;
			have_q  <= have_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cmd_q      <= cmd_d;
		root_q     <= root_d;
		ra_q       <= ra_d;
		ent_q      <= ent_d;
		best_ent_q <= best_ent_d;
		best_idx_q <= best_idx_d;
		best_key_q <= best_key_d;
		rem_a_q    <= rem_a_d;
		res_q      <= res_d;
	end

	assign res = res_q;
endmodule

`default_nettype wire
